>>> rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies; compile first
package deq_pkg;

  // fixed field widths of the request and result items
  localparam int ACTION_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int WORD_W     = 32;

  // default ring depth, handed to the top level parameter
  localparam int DEPTH_DEF  = 16;

  // request codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_CLEAR      = 3'd6
  } action_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request item
    logic exec;     // apply the request to the ring and read the store
  } dp_cmd_t;

endpackage

>>> rtl/deq_in_if.sv
// request channel: valid/ready handshake with action and push word
// depends on deq_pkg
interface deq_in_if import deq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

>>> rtl/deq_out_if.sv
// result channel: valid/ready handshake with status and read word
// depends on deq_pkg
interface deq_out_if import deq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

>>> rtl/double_ended_queue_top.sv
// top level of the double-ended queue: controller plus datapath
// depends on deq_pkg, deq_in_if, deq_out_if, deq_ctrl, deq_dp
//
//   channel   dir   fields                        handshake
//   in_ch     in    action[2:0], push_value[31:0] valid/ready
//   out_ch    out   status[1:0], read_value[31:0] valid/ready
//
// each request item goes through accept, execute (index update, a
// ring memory write for a push and a registered read for the result word),
// then the result item is held on out_ch until taken. the next request is
// accepted the cycle after the result is taken. a stalled result holds the
// block; reset (rst_n low, synchronous) empties the queue and needs no
// clearing pass.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  dp_cmd_t cmd;

  // sequencing
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // ring store and indices
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_action      (in_ch.action),
    .in_push_value  (in_ch.push_value),
    .out_status     (out_ch.status),
    .out_read_value (out_ch.read_value)
  );

endmodule

>>> rtl/deq_ctrl.sv
// controller state machine for the double-ended queue
// depends on deq_pkg
module deq_ctrl import deq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/deq_dp.sv
// datapath: request latch, ring indices, slot store and result register
// depends on deq_pkg
module deq_dp import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [WORD_W-1:0]   in_push_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_read_value
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  // slot store
  logic [WORD_W-1:0] mem [DEPTH];

  action_t           act_r;
  logic [WORD_W-1:0] word_r;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] rd_data_r;

  logic              empty, full;
  logic [AW-1:0]     front_dec, front_inc, tail_idx, back_idx;
  logic [SW-1:0]     sum_fc, sum_fc_m1;
  logic              we;
  logic [AW-1:0]     waddr, raddr;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= action_t'(in_action);
      word_r <= in_push_value;
    end
  end

  // ring index arithmetic
  assign empty     = (count_r == '0);
  assign full      = (count_r == FULL_CNT);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign sum_fc    = SW'(front_r) + SW'(count_r);
  assign sum_fc_m1 = sum_fc - SW'(1);
  assign tail_idx  = (sum_fc >= DEPTH_S) ? AW'(sum_fc - DEPTH_S) : AW'(sum_fc);
  assign back_idx  = (sum_fc_m1 >= DEPTH_S) ? AW'(sum_fc_m1 - DEPTH_S) : AW'(sum_fc_m1);

  // request decode and next state of the ring
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    we         = 1'b0;
    waddr      = tail_idx;
    raddr      = front_r;
    case (act_r)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
          if (act_r == ACT_PUSH_FRONT) begin
            front_nxt = front_dec;
            waddr     = front_dec;
          end
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_VALUE;
          if (act_r == ACT_POP_FRONT) begin
            count_nxt = count_r - CW'(1);
            front_nxt = (count_r == CW'(1)) ? '0 : front_inc;
          end
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        raddr = back_idx;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_VALUE;
          if (act_r == ACT_POP_BACK) begin
            count_nxt = count_r - CW'(1);
            if (count_r == CW'(1)) front_nxt = '0;
          end
        end
      end
      ACT_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // ring control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // result status
  always_ff @(posedge clk) begin
    if (cmd.exec) status_r <= status_nxt;
  end

  // store write port
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[waddr] <= word_r;
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    if (cmd.exec) rd_data_r <= mem[raddr];
  end

  assign out_status     = status_r;
  assign out_read_value = (status_r == ST_VALUE) ? rd_data_r : '0;

endmodule

>>> tb/sv/deq_checker.sv
// scoreboard for the double-ended queue: watches both channels, predicts results
// depends on deq_pkg, deq_in_if, deq_out_if
module deq_checker import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  deq_in_if    in_mon,
  deq_out_if   out_mon,
  output int   mismatch_count,
  output int   awaiting_count
);

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] read_value;
  } deq_result_t;

  // shadow copy of the ring and its indices
  logic [WORD_W-1:0] ring_words [DEPTH] = '{default: '0};
  int unsigned       head_slot = 0;
  int unsigned       fill_level = 0;

  deq_result_t pending_results [$];
  int          fault_total = 0;

  // apply one request to the shadow ring and return its result item
  function automatic deq_result_t deque_predict(input logic [ACTION_W-1:0] act,
                                                input logic [WORD_W-1:0]   word);
    deq_result_t res;
    int unsigned slot;
    res.status     = ST_OK;
    res.read_value = '0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot      = head_slot;
          end else begin
            slot = (head_slot + fill_level) % DEPTH;
          end
          ring_words[slot] = word;
          fill_level++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (fill_level == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)
            slot = head_slot;
          else
            slot = (head_slot + fill_level + DEPTH - 1) % DEPTH;
          res.status     = ST_VALUE;
          res.read_value = ring_words[slot];
          if (act == ACT_POP_FRONT) begin
            head_slot = (head_slot + 1) % DEPTH;
            fill_level--;
          end else if (act == ACT_POP_BACK) begin
            fill_level--;
          end
          // emptying pop puts the front back to slot zero
          if (fill_level == 0 && (act == ACT_POP_FRONT || act == ACT_POP_BACK))
            head_slot = 0;
        end
      end
      ACT_CLEAR: begin
        head_slot  = 0;
        fill_level = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // compare taken results first, then predict the newly accepted request
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("unexpected result item: status %0d value %h",
                     out_mon.status, out_mon.read_value);
        end else begin
          want = pending_results.pop_front();
          if (out_mon.status !== want.status || out_mon.read_value !== want.read_value) begin
            fault_total++;
            if (fault_total <= 10)
              $display("mismatch: expected status %0d value %h, got status %0d value %h",
                       want.status, want.read_value, out_mon.status, out_mon.read_value);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(deque_predict(in_mon.action, in_mon.push_value));
    end
    mismatch_count <= fault_total;
    awaiting_count <= pending_results.size();
  end

endmodule

>>> tb/sv/tb_double_ended_queue_top.sv
// testbench top for the double-ended queue: clock, reset, request stimulus and verdict
// depends on deq_pkg, deq_in_if, deq_out_if, double_ended_queue_top, deq_checker
module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int PHASE_ITEMS = 330;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  int src_idle  = 38;
  int sink_idle = 84;
  int mismatches;
  int awaiting;

  double_ended_queue_top #(.DEPTH(DEPTH_DEF)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deq_checker #(.DEPTH(DEPTH_DEF)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatches),
    .awaiting_count (awaiting)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= sink_idle);

  // offer one request item, idling first at random, and wait for its acceptance
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.push_value <= word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // bias towards pushes while filling and towards pops while draining
  function automatic logic [ACTION_W-1:0] pick_action(input bit filling);
    int r;
    int push_share;
    r = $urandom_range(0, 99);
    push_share = filling ? 65 : 30;
    if (r < 3) return ACT_CLEAR;
    if (r < 5) return ACT_UNUSED;
    if (r < 5 + push_share) return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    case ($urandom_range(0, 3))
      0:       return ACT_POP_FRONT;
      1:       return ACT_POP_BACK;
      2:       return ACT_PEEK_FRONT;
      default: return ACT_PEEK_BACK;
    endcase
  endfunction

  // bursts of filling or draining with random content
  task automatic random_phase(input int count);
    int sent;
    int burst;
    bit filling;
    sent = 0;
    filling = 1'b1;
    while (sent < count) begin
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        send_request(pick_action(filling), pick_word());
        sent++;
      end
      filling = $urandom_range(0, 2) != 0 ? !filling : filling;
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_PUSH_FRONT;
    in_ch.push_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: every read errors, unused code and clear are harmless
    send_request(ACT_POP_FRONT, '1);
    send_request(ACT_POP_BACK, '0);
    send_request(ACT_PEEK_FRONT, '0);
    send_request(ACT_PEEK_BACK, '1);
    send_request(ACT_UNUSED, '1);
    send_request(ACT_CLEAR, '0);
    // popping the only element from either end
    send_request(ACT_PUSH_FRONT, '0);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_PUSH_BACK, '1);
    send_request(ACT_POP_BACK, '0);
    // fill to the brim, then refused pushes and reads at both ends
    for (int i = 0; i < DEPTH_DEF; i++)
      send_request(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom());
    send_request(ACT_PUSH_FRONT, '1);
    send_request(ACT_PUSH_BACK, '1);
    send_request(ACT_PEEK_FRONT, '0);
    send_request(ACT_PEEK_BACK, '0);
    send_request(ACT_CLEAR, '0);

    random_phase(PHASE_ITEMS);
    src_idle  = 84;
    sink_idle = 38;
    random_phase(PHASE_ITEMS);
    src_idle  = 0;
    sink_idle = 0;
    random_phase(PHASE_ITEMS);

    // drain outstanding results before the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && awaiting == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
